>>> src/mtt_pkg.sv
// Shared types and codes for the multi-timer table.
package mtt_pkg;

    localparam int REQ_W   = 2;
    localparam int ID_W    = 4;
    localparam int MS_W    = 24;
    localparam int ELAP_W  = 16;
    localparam int CNT_W   = 32;
    localparam int KIND_W  = 3;

    // Stored entry: {one_shot, reload, count}
    localparam int ENTRY_W = 1 + MS_W + CNT_W;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    localparam logic [KIND_W-1:0] RES_START_OK  = 3'd0;
    localparam logic [KIND_W-1:0] RES_START_REJ = 3'd1;
    localparam logic [KIND_W-1:0] RES_STOP_OK   = 3'd2;
    localparam logic [KIND_W-1:0] RES_STOP_REJ  = 3'd3;
    localparam logic [KIND_W-1:0] RES_EXPIRED   = 3'd4;
    localparam logic [KIND_W-1:0] RES_TICK_NONE = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

>>> src/mtt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/multi_timer_table_core.sv
// Multi-timer table: start/stop/tick requests over a RAM of countdown timers.
//
// Input channel (s_axis): one beat is one request: start, stop or tick.
// Output channel (m_axis): one or more result beats per request; tlast marks
// the final beat of a request. Unknown request codes give no result.
// Start and stop finish in the accept cycle: the result beat is presented on
// the next cycle. A tick scans the timer RAM one slot per cycle, unless the
// receiver stalls, in ascending id order (one read port with registered read
// data, write-back of the slot read the cycle before).
// Each expiry is held one slot back so the final one can carry tlast; a tick
// with no expiry yields a single "tick none" beat.
// Requests are taken one at a time: s_axis tready is high only when no tick
// is running and the output register is empty or being drained.
// When the receiver stalls, the scan pauses on the slot in hand and resumes
// without loss. Reset (synchronous, active low) clears all live and pending
// flags and empties the output; the timer RAM itself is not cleared.
module multi_timer_table_core
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // req_type[1:0], timer_id[5:2], initial_ms[29:6], interval_ms[53:30],
    // one_shot[54], elapsed_ms[70:55], zero pad[71]
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // result_kind[2:0], result_id[6:3], zero pad[7]
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    output logic                o_m_axis_tlast
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Request fields
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   timer_id;
    logic [MS_W-1:0]   initial_ms;
    logic [MS_W-1:0]   interval_ms;
    logic              one_shot;
    logic [ELAP_W-1:0] elapsed_ms;

    assign req_type    = i_s_axis_tdata[1:0];
    assign timer_id    = i_s_axis_tdata[5:2];
    assign initial_ms  = i_s_axis_tdata[29:6];
    assign interval_ms = i_s_axis_tdata[53:30];
    assign one_shot    = i_s_axis_tdata[54];
    assign elapsed_ms  = i_s_axis_tdata[70:55];

    t_state r_state, n_state;

    logic [NUM_TIMERS-1:0] r_live, n_live;
    logic [NUM_TIMERS-1:0] r_pend, n_pend;
    logic [IW:0]           r_rd_idx, n_rd_idx;
    logic                  r_p_vld, n_p_vld;
    logic [IW-1:0]         r_p_idx, n_p_idx;
    logic [ELAP_W-1:0]     r_elapsed, n_elapsed;
    logic                  r_hold_vld, n_hold_vld;
    logic [ID_W-1:0]       r_hold_id, n_hold_id;
    logic                  r_o_valid, n_o_valid;
    logic [KIND_W-1:0]     r_o_kind, n_o_kind;
    logic [ID_W-1:0]       r_o_id, n_o_id;
    logic                  r_o_last, n_o_last;

    // RAM port
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_q;

    mtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Handshake helpers
    logic s_fire;
    logic out_free;

    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // Request decode
    logic          id_in_range;
    logic [IW-1:0] id_ix;
    logic          id_live;
    logic          id_active;

    assign id_in_range = 32'(timer_id) < NUM_TIMERS;
    assign id_ix       = IW'(timer_id);
    assign id_live     = id_in_range && r_live[id_ix];
    assign id_active   = id_live && !r_pend[id_ix];

    // Scan datapath on the slot read last cycle
    logic               q_os;
    logic [MS_W-1:0]    q_rel;
    logic [CNT_W-1:0]   q_cnt;
    logic [CNT_W:0]     diff;
    logic [CNT_W-1:0]   sat_cnt;
    logic               expired;
    logic [CNT_W-1:0]   new_cnt;
    logic               p_live;
    logic               need_push;
    logic               stall;
    logic               rd_more;

    assign q_cnt = ram_q[CNT_W-1:0];
    assign q_rel = ram_q[CNT_W +: MS_W];
    assign q_os  = ram_q[ENTRY_W-1];

    assign diff    = {q_cnt[CNT_W-1], q_cnt} - {{(CNT_W+1-ELAP_W){1'b0}}, r_elapsed};
    // saturate at the most negative 32-bit value
    assign sat_cnt = (diff[CNT_W] && !diff[CNT_W-1]) ? {1'b1, {(CNT_W-1){1'b0}}}
                                                     : diff[CNT_W-1:0];
    assign expired = sat_cnt[CNT_W-1];
    assign new_cnt = (expired && !q_os) ? sat_cnt + {{(CNT_W-MS_W){1'b0}}, q_rel}
                                        : sat_cnt;

    assign p_live    = r_p_vld && r_live[r_p_idx];
    assign need_push = p_live && expired && r_hold_vld;
    assign stall     = (r_state == ST_SCAN) && need_push && !out_free;
    assign rd_more   = r_rd_idx < (IW+1)'(NUM_TIMERS);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_fire && req_type == REQ_TICK) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!r_p_vld && !rd_more) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_live     = r_live;
        n_pend     = r_pend;
        n_rd_idx   = r_rd_idx;
        n_p_vld    = r_p_vld;
        n_p_idx    = r_p_idx;
        n_elapsed  = r_elapsed;
        n_hold_vld = r_hold_vld;
        n_hold_id  = r_hold_id;
        n_o_valid  = r_o_valid && !i_m_axis_tready;
        n_o_kind   = r_o_kind;
        n_o_id     = r_o_id;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = r_rd_idx[IW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    case (req_type)
                        REQ_START: begin
                            n_o_valid = 1'b1;
                            n_o_id    = timer_id;
                            n_o_last  = 1'b1;
                            if (!id_in_range || id_active) begin
                                n_o_kind = RES_START_REJ;
                            end else begin
                                n_o_kind = RES_START_OK;
                                // a start on a pending-stop slot leaves it alone
                                if (!id_live) begin
                                    n_live[id_ix] = 1'b1;
                                    n_pend[id_ix] = 1'b0;
                                    ram_we        = 1'b1;
                                    ram_waddr     = id_ix;
                                    ram_wdata     = {one_shot, interval_ms,
                                                     {(CNT_W-MS_W){1'b0}}, initial_ms};
                                end
                            end
                        end
                        REQ_STOP: begin
                            n_o_valid = 1'b1;
                            n_o_id    = timer_id;
                            n_o_last  = 1'b1;
                            if (id_active) begin
                                n_o_kind      = RES_STOP_OK;
                                n_pend[id_ix] = 1'b1;
                            end else begin
                                n_o_kind = RES_STOP_REJ;
                            end
                        end
                        REQ_TICK: begin
                            n_elapsed  = elapsed_ms;
                            n_rd_idx   = '0;
                            n_p_vld    = 1'b0;
                            n_hold_vld = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (stall) begin
                    // re-read the slot in hand so its data is there next cycle
                    ram_raddr = r_p_idx;
                end else begin
                    n_p_vld  = rd_more;
                    n_p_idx  = r_rd_idx[IW-1:0];
                    n_rd_idx = r_rd_idx + (IW+1)'(rd_more);
                    if (p_live) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_p_idx;
                        ram_wdata = {q_os, q_rel, new_cnt};
                        // slot is not visited again this tick: drop it now
                        if (r_pend[r_p_idx] || (expired && q_os)) begin
                            n_live[r_p_idx] = 1'b0;
                            n_pend[r_p_idx] = 1'b0;
                        end
                        if (expired) begin
                            n_hold_vld = 1'b1;
                            n_hold_id  = ID_W'(r_p_idx);
                        end
                        if (need_push) begin
                            n_o_valid = 1'b1;
                            n_o_kind  = RES_EXPIRED;
                            n_o_id    = r_hold_id;
                            n_o_last  = 1'b0;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_last  = 1'b1;
                    if (r_hold_vld) begin
                        n_o_kind = RES_EXPIRED;
                        n_o_id   = r_hold_id;
                    end else begin
                        n_o_kind = RES_TICK_NONE;
                        n_o_id   = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_live     <= '0;
            r_pend     <= '0;
            r_p_vld    <= 1'b0;
            r_hold_vld <= 1'b0;
            r_o_valid  <= 1'b0;
            r_rd_idx   <= '0;
        end else begin
            r_state    <= n_state;
            r_live     <= n_live;
            r_pend     <= n_pend;
            r_p_vld    <= n_p_vld;
            r_hold_vld <= n_hold_vld;
            r_o_valid  <= n_o_valid;
            r_rd_idx   <= n_rd_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_p_idx   <= n_p_idx;
        r_elapsed <= n_elapsed;
        r_hold_id <= n_hold_id;
        r_o_kind  <= n_o_kind;
        r_o_id    <= n_o_id;
        r_o_last  <= n_o_last;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {1'b0, r_o_id, r_o_kind};
    assign o_m_axis_tlast  = r_o_last;

endmodule

>>> tb/multi_timer_table_core_test.sv
// Self-checking testbench for multi_timer_table_core: directed table, then a random run.
module multi_timer_table_core_test
    import mtt_pkg::*;
;

    localparam int          SLOTS       = 16;
    localparam int          RAND_ITEMS  = 440;
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int          DRAIN_WAIT  = 60;
    localparam int          N_DIR       = 22;
    localparam int          MAX_PRINTS  = 50;
    localparam longint      CNT_MIN     = -64'sd2147483648;

    // req_type 3 is not decoded by the block
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [ID_W-1:0]   id;
        logic [MS_W-1:0]   init_ms;
        logic [MS_W-1:0]   intv_ms;
        logic              shot;
        logic [ELAP_W-1:0] elapsed;
    } t_req;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              tail;
    } t_result;

    typedef struct {
        t_req              rq;
        bit                typed;
        logic [KIND_W-1:0] kind;
    } t_row;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                s_valid = 1'b0;
    logic [S_DATA_W-1:0] s_data  = '0;
    logic                m_ready = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [M_DATA_W-1:0] m_data;
    logic                m_last;

    // timer table as the testbench sees it
    bit                      slot_on       [SLOTS] = '{default: 1'b0};
    bit                      slot_stopping [SLOTS] = '{default: 1'b0};
    bit                      slot_single   [SLOTS] = '{default: 1'b0};
    logic signed [CNT_W-1:0] slot_count    [SLOTS] = '{default: '0};
    logic [MS_W-1:0]         slot_reload   [SLOTS] = '{default: '0};

    t_result     req_results [$];
    t_result     results_due [$];
    int          err_cnt    = 0;
    int unsigned cycle_cnt  = 0;
    int          stall_left = 0;
    bit          tx_gaps    = 1'b1;
    bit          rx_gaps    = 1'b1;
    t_row        dir_rows [N_DIR];

    multi_timer_table_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        if (err_cnt < MAX_PRINTS)
            $display("MISMATCH @%0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    // mostly zero, sometimes a few cycles, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_request(input t_req r);
        return {1'b0, r.elapsed, r.shot, r.intv_ms, r.init_ms, r.id, r.req};
    endfunction

    // Updates the table for one request and leaves its result beats in req_results.
    task automatic compute_timer_results(input t_req r);
        longint c;
        req_results.delete();
        case (r.req)
            REQ_START: begin
                if (slot_on[r.id] && !slot_stopping[r.id]) begin
                    req_results.push_back(t_result'{RES_START_REJ, r.id, 1'b1});
                end else begin
                    // a start on a stopping slot is acknowledged but changes nothing
                    if (!slot_on[r.id]) begin
                        slot_on[r.id]       = 1'b1;
                        slot_stopping[r.id] = 1'b0;
                        slot_single[r.id]   = r.shot;
                        slot_count[r.id]    = {8'd0, r.init_ms};
                        slot_reload[r.id]   = r.intv_ms;
                    end
                    req_results.push_back(t_result'{RES_START_OK, r.id, 1'b1});
                end
            end
            REQ_STOP: begin
                if (slot_on[r.id] && !slot_stopping[r.id]) begin
                    slot_stopping[r.id] = 1'b1;
                    req_results.push_back(t_result'{RES_STOP_OK, r.id, 1'b1});
                end else begin
                    req_results.push_back(t_result'{RES_STOP_REJ, r.id, 1'b1});
                end
            end
            REQ_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_on[i]) begin
                        c = longint'(slot_count[i]) - longint'(r.elapsed);
                        if (c < CNT_MIN)
                            c = CNT_MIN;
                        if (c < 0) begin
                            req_results.push_back(t_result'{RES_EXPIRED, ID_W'(i), 1'b0});
                            if (slot_single[i])
                                slot_stopping[i] = 1'b1;
                            else
                                c += longint'(slot_reload[i]);
                        end
                        slot_count[i] = c[CNT_W-1:0];
                    end
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_stopping[i]) begin
                        slot_on[i]       = 1'b0;
                        slot_stopping[i] = 1'b0;
                    end
                end
                if (req_results.size() == 0)
                    req_results.push_back(t_result'{RES_TICK_NONE, '0, 1'b1});
                else
                    req_results[req_results.size() - 1].tail = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_request(input t_req r, input int gap, input bit typed,
                                input logic [KIND_W-1:0] typed_kind);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= pack_request(r);
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        compute_timer_results(r);
        if (typed)
            results_due.push_back(t_result'{typed_kind, r.id, 1'b1});
        else
            foreach (req_results[k])
                results_due.push_back(req_results[k]);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic t_req random_request();
        t_req r;
        int   p;
        r.id      = ID_W'($urandom_range(0, SLOTS - 1));
        r.init_ms = ($urandom_range(0, 99) < 85) ? MS_W'($urandom_range(0, 3000))
                                                 : MS_W'($urandom_range(0, 24'hFFFFFF));
        r.intv_ms = ($urandom_range(0, 99) < 85) ? MS_W'($urandom_range(1, 3000))
                                                 : MS_W'($urandom_range(0, 24'hFFFFFF));
        r.shot    = 1'($urandom_range(0, 1));
        r.elapsed = ($urandom_range(0, 99) < 80) ? ELAP_W'($urandom_range(0, 600))
                                                 : ELAP_W'($urandom_range(0, 16'hFFFF));
        p = $urandom_range(0, 99);
        if (p < 40)
            r.req = REQ_START;
        else if (p < 62)
            r.req = REQ_STOP;
        else if (p < 96)
            r.req = REQ_TICK;
        else
            r.req = REQ_UNUSED;
        return r;
    endfunction

    always @(posedge clk) begin
        if (!rx_gaps) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat kind %0d id %0d last %0b",
                                        m_data[2:0], m_data[6:3], m_last));
            end else begin
                want = results_due.pop_front();
                if (m_data[2:0] !== want.kind)
                    flag_mismatch($sformatf("kind %0d, expected %0d (id %0d)",
                                            m_data[2:0], want.kind, want.id));
                if (m_data[6:3] !== want.id)
                    flag_mismatch($sformatf("id %0d, expected %0d", m_data[6:3], want.id));
                if (m_last !== want.tail)
                    flag_mismatch($sformatf("tlast %0b, expected %0b (id %0d)",
                                            m_last, want.tail, want.id));
                if (m_data[7] !== 1'b0)
                    flag_mismatch("tdata pad bit not zero");
            end
        end
    end

    initial begin : stimulus
        t_req r;
        int   done_cnt;
        int   next_block;
        bit   paused;

        dir_rows = '{
            '{'{REQ_TICK,   4'd0,  24'd0,        24'd0,        1'b0, 16'd0},
              1'b1, RES_TICK_NONE},
            '{'{REQ_STOP,   4'd3,  24'd0,        24'd0,        1'b0, 16'd0},
              1'b1, RES_STOP_REJ},
            '{'{REQ_START,  4'd0,  24'd0,        24'hFFFFFF,   1'b0, 16'd0},
              1'b1, RES_START_OK},
            '{'{REQ_START,  4'd0,  24'd123,      24'd5,        1'b1, 16'd0},
              1'b1, RES_START_REJ},
            '{'{REQ_START,  4'd15, 24'hFFFFFF,   24'd0,        1'b1, 16'd0},
              1'b1, RES_START_OK},
            '{'{REQ_START,  4'd7,  24'd5,        24'd10,       1'b1, 16'd0},
              1'b1, RES_START_OK},
            '{'{REQ_START,  4'd8,  24'd3,        24'd2,        1'b0, 16'd0},
              1'b1, RES_START_OK},
            // a count of exactly zero has not expired
            '{'{REQ_TICK,   4'd0,  24'd0,        24'd0,        1'b0, 16'd0},
              1'b1, RES_TICK_NONE},
            '{'{REQ_TICK,   4'd0,  24'd0,        24'd0,        1'b0, 16'd1},
              1'b0, RES_TICK_NONE},
            '{'{REQ_STOP,   4'd8,  24'd0,        24'd0,        1'b0, 16'd0},
              1'b1, RES_STOP_OK},
            // already stopping
            '{'{REQ_STOP,   4'd8,  24'd0,        24'd0,        1'b0, 16'd0},
              1'b1, RES_STOP_REJ},
            // start on a stopping slot: acknowledged, no effect
            '{'{REQ_START,  4'd8,  24'd9,        24'd9,        1'b1, 16'd0},
              1'b1, RES_START_OK},
            // stopping timer still expires on its last tick
            '{'{REQ_TICK,   4'd0,  24'd0,        24'd0,        1'b0, 16'd5},
              1'b0, RES_TICK_NONE},
            '{'{REQ_TICK,   4'd0,  24'd0,        24'd0,        1'b0, 16'hFFFF},
              1'b0, RES_TICK_NONE},
            '{'{REQ_STOP,   4'd7,  24'd0,        24'd0,        1'b0, 16'd0},
              1'b1, RES_STOP_REJ},
            '{'{REQ_UNUSED, 4'd15, 24'hFFFFFF,   24'hFFFFFF,   1'b1, 16'hFFFF},
              1'b0, RES_TICK_NONE},
            '{'{REQ_START,  4'd7,  24'hFFFFFF,   24'hFFFFFF,   1'b1, 16'hFFFF},
              1'b1, RES_START_OK},
            '{'{REQ_STOP,   4'd15, 24'hFFFFFF,   24'hFFFFFF,   1'b1, 16'hFFFF},
              1'b1, RES_STOP_OK},
            '{'{REQ_TICK,   4'd15, 24'hFFFFFF,   24'hFFFFFF,   1'b1, 16'd0},
              1'b0, RES_TICK_NONE},
            '{'{REQ_START,  4'd15, 24'd0,        24'd0,        1'b0, 16'd0},
              1'b1, RES_START_OK},
            '{'{REQ_STOP,   4'd0,  24'd0,        24'd0,        1'b0, 16'd0},
              1'b1, RES_STOP_OK},
            '{'{REQ_TICK,   4'd0,  24'd0,        24'd0,        1'b0, 16'hFFFF},
              1'b0, RES_TICK_NONE}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].rq, pick_gap(), dir_rows[i].typed, dir_rows[i].kind);

        done_cnt   = 0;
        next_block = 0;
        paused     = 1'b0;
        while (done_cnt < RAND_ITEMS) begin
            if (done_cnt >= next_block) begin
                tx_gaps    = ($urandom_range(0, 2) != 0);
                rx_gaps    = ($urandom_range(0, 2) != 0);
                next_block = next_block + 40;
            end
            r = random_request();
            send_request(r, tx_gaps ? pick_gap() : 0, 1'b0, RES_START_OK);
            if (r.req != REQ_UNUSED)
                done_cnt++;
            if (!paused && done_cnt == RAND_ITEMS / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end

        s_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
